/* hdl/urrb_pkg.sv */
// Package for the serial receiver with receive ring buffer.
// Holds shared types, command codes and fixed constants; no dependencies.
package urrb_pkg;

   localparam int TickRateHz  = 1000000;
   localparam int DefaultBaud = 19200;

   localparam logic [15:0] BIT_PERIOD_RESET = 16'(TickRateHz / DefaultBaud);
   localparam logic [7:0]  EMPTY_CHAR       = 8'd35;

   // Request command codes.
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // Depth of the output queue that holds responses in the back.
   localparam int QDepth = 3;

   typedef enum logic [2:0] {
      RX_IDLE = 3'b001,
      RX_DATA = 3'b010,
      RX_STOP = 3'b100
   } rx_state_type;

   // What the front hands to the back for one request.
   typedef struct packed {
      logic       valid;
      logic       is_read;
      logic       popped;
      logic       done;
      logic [3:0] avail;
   } front_out_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       read_valid;
      logic       byte_done;
      logic [3:0] bytes_available;
   } result_type;

endpackage

/* hdl/urrb_if.sv */
// Request and response channel interfaces of the serial receiver.
// Plain valid/ready channels; no dependencies.
interface urrb_req_if;
   logic valid;
   logic ready;
   logic cmd;
   logic line_level;

   modport source (output valid, output cmd, output line_level, input ready);
   modport sink   (input valid, input cmd, input line_level, output ready);
endinterface

interface urrb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       read_valid;
   logic       byte_done;
   logic [3:0] bytes_available;

   modport source (output valid, output read_data, output read_valid,
                   output byte_done, output bytes_available, input ready);
   modport sink   (input valid, input read_data, input read_valid,
                   input byte_done, input bytes_available, output ready);
endinterface

/* hdl/urrb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module urrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/urrb_front.sv */
// Front of the serial receiver: accepts requests, runs the bit timer and
// receive state machine, keeps the ring indices and drives the byte RAM.
// Depends on urrb_pkg and urrb_if.
module urrb_front import urrb_pkg::*; #(
   parameter int BUF_DEPTH = 16,
   localparam int IdxW = $clog2(BUF_DEPTH)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_wr_en,
   input  logic [15:0]     csr_wr_data,
   urrb_req_if.sink        req_chan,
   input  logic            room,
   output front_out_type   fout,
   output logic            ram_wr_en,
   output logic [IdxW-1:0] ram_wr_addr,
   output logic [7:0]      ram_wr_data,
   output logic            ram_rd_en,
   output logic [IdxW-1:0] ram_rd_addr
);

   rx_state_type    state_ff, state_in;
   logic [2:0]      bitcnt_ff, bitcnt_in;
   logic [15:0]     timer_ff, timer_in;
   logic [15:0]     period_ff;
   logic [7:0]      shreg_ff, shreg_in;
   logic            prev_ff, prev_in;
   logic [IdxW-1:0] wr_idx_ff, wr_idx_in;
   logic [IdxW-1:0] rd_idx_ff, rd_idx_in;

   logic            accept;
   logic            popped;
   logic            done;
   logic [15:0]     timer_inc;
   logic            fire;
   logic [IdxW:0]   count;
   logic [IdxW+4:0] count_ext;

   assign accept         = req_chan.valid && room;
   assign req_chan.ready = room;

   assign timer_inc = timer_ff + 16'd1;
   // A timer that wrapped to zero also samples, so a zero period acts as one.
   assign fire      = (timer_inc >= period_ff) || (timer_inc == 16'd0);

   always_comb begin
      state_in  = state_ff;
      bitcnt_in = bitcnt_ff;
      timer_in  = timer_ff;
      shreg_in  = shreg_ff;
      prev_in   = prev_ff;
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      popped    = 1'b0;
      done      = 1'b0;
      if (accept) begin
         if (req_chan.cmd == CMD_READ) begin
            if (wr_idx_ff != rd_idx_ff) begin
               popped    = 1'b1;
               rd_idx_in = (rd_idx_ff == IdxW'(BUF_DEPTH - 1)) ? '0 : rd_idx_ff + IdxW'(1);
            end
         end else begin
            prev_in = req_chan.line_level;
            unique case (state_ff)
               RX_IDLE: begin
                  if (prev_ff && !req_chan.line_level) begin
                     state_in  = RX_DATA;
                     bitcnt_in = 3'd0;
                     timer_in  = 16'd0;
                  end
               end
               RX_DATA: begin
                  timer_in = fire ? 16'd0 : timer_inc;
                  if (fire) begin
                     // LSB arrives first, so shift in from the top.
                     shreg_in  = {req_chan.line_level, shreg_ff[7:1]};
                     bitcnt_in = bitcnt_ff + 3'd1;
                     if (bitcnt_ff == 3'd7) begin
                        state_in = RX_STOP;
                     end
                  end
               end
               RX_STOP: begin
                  timer_in = fire ? 16'd0 : timer_inc;
                  if (fire) begin
                     state_in  = RX_IDLE;
                     done      = 1'b1;
                     wr_idx_in = (wr_idx_ff == IdxW'(BUF_DEPTH - 1)) ? '0
                                                                     : wr_idx_ff + IdxW'(1);
                  end
               end
               default: begin
                  state_in = RX_IDLE;
               end
            endcase
         end
      end
   end

   assign count = {1'b0, wr_idx_in} - {1'b0, rd_idx_in}
                + ((wr_idx_in < rd_idx_in) ? (IdxW+1)'(BUF_DEPTH) : '0);
   assign count_ext = (IdxW+5)'(count);

   always_comb begin
      fout.valid   = accept;
      fout.is_read = (req_chan.cmd == CMD_READ);
      fout.popped  = popped;
      fout.done    = done;
      fout.avail   = count_ext[3:0];
   end

   // The assembled byte is written once, when the stop sample ends it.
   assign ram_wr_en   = done;
   assign ram_wr_addr = wr_idx_ff;
   assign ram_wr_data = shreg_ff;
   assign ram_rd_en   = popped;
   assign ram_rd_addr = rd_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= RX_IDLE;
         bitcnt_ff <= 3'd0;
         timer_ff  <= 16'd0;
         period_ff <= BIT_PERIOD_RESET;
         prev_ff   <= 1'b1;
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
      end else begin
         state_ff  <= state_in;
         bitcnt_ff <= bitcnt_in;
         timer_ff  <= timer_in;
         prev_ff   <= prev_in;
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         if (csr_wr_en) begin
            period_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      shreg_ff <= shreg_in;
   end

endmodule

/* hdl/urrb_back.sv */
// Back of the serial receiver: joins front records with RAM read data and
// queues finished responses. Depends on urrb_pkg and urrb_if.
module urrb_back import urrb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  front_out_type fout,
   input  logic [7:0]    ram_rd_data,
   output logic          room,
   urrb_rsp_if.source    rsp_chan
);

   localparam int PtrW = $clog2(QDepth);
   localparam int CntW = $clog2(QDepth + 1);

   front_out_type p1_ff;
   result_type    res;
   result_type    q_ff [QDepth];
   logic [PtrW-1:0] head_ff, tail_ff;
   logic [CntW-1:0] cnt_ff;
   logic            push;
   logic            pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff <= '0;
      end else begin
         p1_ff <= fout;
      end
   end

   always_comb begin
      res.read_data       = p1_ff.is_read ? (p1_ff.popped ? ram_rd_data : EMPTY_CHAR)
                                          : 8'd0;
      res.read_valid      = p1_ff.popped;
      res.byte_done       = p1_ff.done;
      res.bytes_available = p1_ff.avail;
   end

   assign push = p1_ff.valid;
   assign pop  = rsp_chan.valid && rsp_chan.ready;
   // Room counts the request in the join stage, which always enters the queue.
   assign room = ((CntW+1)'(cnt_ff) + (CntW+1)'(p1_ff.valid)) < (CntW+1)'(QDepth);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (push) begin
            tail_ff <= (tail_ff == PtrW'(QDepth - 1)) ? '0 : tail_ff + PtrW'(1);
         end
         if (pop) begin
            head_ff <= (head_ff == PtrW'(QDepth - 1)) ? '0 : head_ff + PtrW'(1);
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + CntW'(1);
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - CntW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[tail_ff] <= res;
      end
   end

   assign rsp_chan.valid           = (cnt_ff != '0);
   assign rsp_chan.read_data       = q_ff[head_ff].read_data;
   assign rsp_chan.read_valid      = q_ff[head_ff].read_valid;
   assign rsp_chan.byte_done       = q_ff[head_ff].byte_done;
   assign rsp_chan.bytes_available = q_ff[head_ff].bytes_available;

endmodule

/* hdl/uart_receiver_with_ring_buffer_core.sv */
// Serial 8N1 receiver with a receive ring buffer, top level.
// A response passes through the RAM read and join stage and then the output
// queue before it is offered.
// Throughput: one request per cycle while the back has room.
// Reset is synchronous and clears receiver, timer, indices and queue; the
// bit period returns to 52. The byte RAM is not cleared.
module uart_receiver_with_ring_buffer_core import urrb_pkg::*; #(
   parameter int BUF_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   urrb_req_if.sink    req_chan,
   urrb_rsp_if.source  rsp_chan
);

   localparam int IdxW = $clog2(BUF_DEPTH);

   front_out_type   fout;
   logic            room;
   logic            ram_wr_en;
   logic [IdxW-1:0] ram_wr_addr;
   logic [7:0]      ram_wr_data;
   logic            ram_rd_en;
   logic [IdxW-1:0] ram_rd_addr;
   logic [7:0]      ram_rd_data;

   // The front handles every request in the cycle it is accepted: ticks
   // advance the receiver, reads of a non-empty buffer move the read index and start a RAM read.
   urrb_front #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .room        (room),
      .fout        (fout),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr)
   );

   // Ring buffer storage. A byte written at one edge is readable by a read
   // issued at the next, so a read right after a completed byte sees it.
   urrb_ram #(
      .WIDTH (8),
      .DEPTH (BUF_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // The back lines up the RAM data with its request and queues the
   // response, so a stalled consumer does not stop the front at once.
   urrb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .fout        (fout),
      .ram_rd_data (ram_rd_data),
      .room        (room),
      .rsp_chan    (rsp_chan)
   );

   // A tick never reads the RAM and a read never writes it.
   a_ram_one_port: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("RAM written and read in the same cycle");

   // A response cannot both pop a byte and complete one.
   a_rsp_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.read_valid && rsp_chan.byte_done))
      else $error("response both popped and completed a byte");

   // Without a popped byte the data is either zero (tick) or the empty mark.
   a_empty_mark: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.read_valid && (rsp_chan.read_data != 8'd0))
      |-> (rsp_chan.read_data == EMPTY_CHAR))
      else $error("unexpected data on a response without a popped byte");

   // Nothing is offered in the first cycle after reset is released.
   a_reset_quiet: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp_chan.valid)
      else $error("response offered right after reset");

endmodule
